[hdl/quaternion_arithmetic_unit_assert.svh]
// Assertion macros shared by the quaternion arithmetic unit RTL.
// Needs a clock named clk and an active-low reset named arst_n in the including scope.
`ifndef QUATERNION_ARITHMETIC_UNIT_ASSERT_SVH
`define QUATERNION_ARITHMETIC_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define QAU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define QAU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/qau_pkg.sv]
// Types, widths and operation codes of the quaternion arithmetic unit.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps
`default_nettype none

package qau_pkg;

	localparam int FRAC_BITS = 16;
	localparam int Q_W       = 32;
	localparam int OP_W      = 3;
	localparam int ST_W      = 2;
	localparam int IN_DATA_W  = 9 * Q_W;
	localparam int OUT_DATA_W = 5 * Q_W;

	localparam int PROD_W = 2 * Q_W;
	localparam int SQ_W   = PROD_W + 1;
	localparam int ROOT_W = 33;
	localparam int RAD_W  = 2 * ROOT_W;
	localparam int REM_W  = ROOT_W + 2;
	localparam int DIV_W  = SQ_W - FRAC_BITS;
	localparam int MAG_W  = Q_W + FRAC_BITS;
	localparam int NUM_W  = ((MAG_W > DIV_W - 1) ? MAG_W : DIV_W - 1) + 1;
	localparam int MR_W   = PROD_W - FRAC_BITS;
	localparam int ACC_W  = MR_W + 2;

	typedef enum logic [OP_W-1:0] {
		OP_MUL, OP_SCALE, OP_DIVIDE, OP_CONJ, OP_DOT, OP_NORM, OP_INV, OP_DIFF
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK   = 2'd0,
		ST_ZERO = 2'd1,
		ST_SAT  = 2'd2
	} status_t;

	typedef logic signed [Q_W-1:0] q_t;
	typedef q_t [3:0] quat_t;

	typedef struct packed {
		op_t   op;
		quat_t a;
		quat_t b;
		q_t    s;
		logic  err;
		logic  sat;
		quat_t qd;
	} item_t;

endpackage

`default_nettype wire

[hdl/quaternion_arithmetic_unit.sv]
// Quaternion arithmetic unit: fully pipelined Q16.16 quaternion ALU.
// Depends on qau_pkg and on the macros in quaternion_arithmetic_unit_assert.svh.
//
// Usage
// A request enters on the s_ group: s_tuser carries the opcode and s_tdata the
// quaternions A and B and the scalar. One result leaves on the m_ group per
// request, in order: m_tdata carries the quaternion result and the dot product,
// m_tuser the status (ok, zero divisor or zero length, saturated).
// The datapath is a single pipeline: two stages form the sum of squares of A,
// 33 stages extract its square root one result bit at a time, one stage sets up
// the four divisions, 49 restoring-division stages produce one quotient bit
// each, and five further stages saturate the quotients, multiply, round, sum
// and saturate into the output register. With no stall a new request is
// accepted on every cycle, so throughput is one request per cycle.
// The final stage is an output register. When the receiver holds m_tready low
// with a result waiting, the whole pipeline freezes and s_tready falls; nothing
// is lost or repeated. The pipeline advances only while the output register is
// empty or being drained, so bubbles inside the pipe are not closed up by a stall.
// Asynchronous reset clears every valid bit, so no result is presented after
// reset until a new request has passed through. The unit holds no other state.
`timescale 1ns / 1ps
`default_nettype none
`include "quaternion_arithmetic_unit_assert.svh"

module quaternion_arithmetic_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, scalar_value (lowest first)
	input  logic [qau_pkg::IN_DATA_W-1:0]     s_tdata,
	// opcode
	input  logic [qau_pkg::OP_W-1:0]          s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// r_w, r_x, r_y, r_z, dot_result (lowest first)
	output logic [qau_pkg::OUT_DATA_W-1:0]    m_tdata,
	// status
	output logic [qau_pkg::ST_W-1:0]          m_tuser
);
	import qau_pkg::*;

	localparam logic signed [PROD_W-1:0] HALF_P = PROD_W'(1) << (FRAC_BITS - 1);
	localparam logic [SQ_W-1:0] HALF_S = SQ_W'(1) << (FRAC_BITS - 1);
	localparam q_t Q_MAX_V = {1'b0, {(Q_W - 1){1'b1}}};
	localparam q_t Q_MIN_V = {1'b1, {(Q_W - 1){1'b0}}};
	localparam logic [NUM_W-1:0] QPOS_MAX = {{(NUM_W - Q_W + 1){1'b0}}, {(Q_W - 1){1'b1}}};
	localparam logic [NUM_W-1:0] QNEG_MAX = {{(NUM_W - Q_W){1'b0}}, 1'b1, {(Q_W - 1){1'b0}}};
	localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(Q_MAX_V);
	localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(Q_MIN_V);

	function automatic logic out_of_range(input logic signed [ACC_W-1:0] v);
		return (v > ACC_MAX) || (v < ACC_MIN);
	endfunction

	function automatic q_t clamp_q(input logic signed [ACC_W-1:0] v);
		if (v > ACC_MAX) begin
			return Q_MAX_V;
		end
		if (v < ACC_MIN) begin
			return Q_MIN_V;
		end
		return Q_W'(v);
	endfunction

	// The pipeline advances whenever the output register is empty or being drained.
	logic en;
	logic ovld_q;
	assign en       = !ovld_q || m_tready;
	assign s_tready = en;

	// Request unpacking.
	item_t in_item;
	always_comb begin
		in_item     = '0;
		in_item.op  = op_t'(s_tuser);
		for (int k = 0; k < 4; k++) begin
			in_item.a[k] = s_tdata[Q_W*k +: Q_W];
			in_item.b[k] = s_tdata[Q_W*(4 + k) +: Q_W];
		end
		in_item.s = s_tdata[Q_W*8 +: Q_W];
	end

	// Stage 1: squares of the components of A.
	logic                    v_s1;
	item_t                   it_s1;
	logic [PROD_W-1:0]       sq_s1 [4];
	logic signed [PROD_W-1:0] sq_c [4];

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			sq_c[k] = in_item.a[k] * in_item.a[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s1 <= in_item;
			for (int k = 0; k < 4; k++) begin
				sq_s1[k] <= sq_c[k];
			end
		end
	end

	// Stage 2: exact sum of squares.
	logic            v_s2;
	item_t           it_s2;
	logic [SQ_W-1:0] sum_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s2  <= it_s1;
			sum_s2 <= SQ_W'(sq_s1[0]) + SQ_W'(sq_s1[1]) + SQ_W'(sq_s1[2]) + SQ_W'(sq_s1[3]);
		end
	end

	// Square root stages: one root bit per stage. The rounded norm A.A rides alongside.
	logic              v_r    [ROOT_W];
	item_t             it_r   [ROOT_W];
	logic [RAD_W-1:0]  rad_r  [ROOT_W];
	logic [REM_W-1:0]  rem_r  [ROOT_W];
	logic [ROOT_W-1:0] root_r [ROOT_W];
	logic [DIV_W-1:0]  n_r    [ROOT_W];

	logic [RAD_W-1:0]  rad_in  [ROOT_W];
	logic [REM_W-1:0]  rem_in  [ROOT_W];
	logic [ROOT_W-1:0] root_in [ROOT_W];
	logic [REM_W+1:0]  rt_cur  [ROOT_W];
	logic [REM_W+1:0]  rt_try  [ROOT_W];
	logic [RAD_W-1:0]  rad_nx  [ROOT_W];
	logic [REM_W-1:0]  rem_nx  [ROOT_W];
	logic [ROOT_W-1:0] root_nx [ROOT_W];
	logic [DIV_W-1:0]  n_first;

	assign n_first = DIV_W'((sum_s2 + HALF_S) >> FRAC_BITS);

	always_comb begin
		for (int k = 0; k < ROOT_W; k++) begin
			if (k == 0) begin
				rad_in[k]  = RAD_W'(sum_s2);
				rem_in[k]  = '0;
				root_in[k] = '0;
			end else begin
				rad_in[k]  = rad_r[k-1];
				rem_in[k]  = rem_r[k-1];
				root_in[k] = root_r[k-1];
			end
			rt_cur[k] = {rem_in[k], rad_in[k][RAD_W-1 -: 2]};
			rt_try[k] = (REM_W + 2)'({root_in[k], 2'b01});
			rad_nx[k] = rad_in[k] << 2;
			if (rt_cur[k] >= rt_try[k]) begin
				rem_nx[k]  = REM_W'(rt_cur[k] - rt_try[k]);
				root_nx[k] = {root_in[k][ROOT_W-2:0], 1'b1};
			end else begin
				rem_nx[k]  = REM_W'(rt_cur[k]);
				root_nx[k] = {root_in[k][ROOT_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < ROOT_W; k++) begin
				v_r[k] <= 1'b0;
			end
		end else if (en) begin
			v_r[0] <= v_s2;
			for (int k = 1; k < ROOT_W; k++) begin
				v_r[k] <= v_r[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_r[0] <= it_s2;
			n_r[0]  <= n_first;
			for (int k = 1; k < ROOT_W; k++) begin
				it_r[k] <= it_r[k-1];
				n_r[k]  <= n_r[k-1];
			end
			for (int k = 0; k < ROOT_W; k++) begin
				rad_r[k]  <= rad_nx[k];
				rem_r[k]  <= rem_nx[k];
				root_r[k] <= root_nx[k];
			end
		end
	end

	// Division set-up: pick the divisor, take magnitudes and pre-add half the divisor.
	logic             v_p;
	item_t            it_p;
	logic [DIV_W-1:0] d_p;
	logic [NUM_W-1:0] u_p   [4];
	logic             neg_p [4];

	item_t             pre_it;
	logic [DIV_W-1:0]  pre_d;
	logic              pre_dneg;
	logic              pre_inv;
	logic [Q_W:0]      s_ext;
	logic [Q_W:0]      s_mag;
	logic [ROOT_W-1:0] len_c;
	logic [DIV_W-1:0]  n_c;
	logic signed [Q_W:0] num_c [4];
	logic [Q_W:0]      mag_c [4];
	logic [NUM_W-1:0]  u_c   [4];
	logic              neg_c [4];

	always_comb begin
		pre_it   = it_r[ROOT_W-1];
		len_c    = root_r[ROOT_W-1];
		n_c      = n_r[ROOT_W-1];
		s_ext    = {pre_it.s[Q_W-1], pre_it.s};
		s_mag    = pre_it.s[Q_W-1] ? -s_ext : s_ext;
		pre_dneg = 1'b0;
		pre_inv  = 1'b0;
		unique case (pre_it.op)
			OP_DIVIDE: begin
				pre_d      = DIV_W'(s_mag);
				pre_dneg   = pre_it.s[Q_W-1];
				pre_it.err = (pre_it.s == '0);
			end
			OP_NORM: begin
				pre_d      = DIV_W'(len_c);
				pre_it.err = (len_c == '0);
			end
			OP_INV, OP_DIFF: begin
				pre_d      = n_c;
				pre_inv    = 1'b1;
				pre_it.err = (n_c == '0);
			end
			OP_MUL, OP_SCALE, OP_CONJ, OP_DOT: begin
				pre_d = DIV_W'(1);
			end
		endcase
		for (int k = 0; k < 4; k++) begin
			num_c[k] = {pre_it.a[k][Q_W-1], pre_it.a[k]};
			if (pre_inv && (k != 0)) begin
				num_c[k] = -num_c[k];
			end
			mag_c[k] = num_c[k][Q_W] ? -num_c[k] : num_c[k];
			neg_c[k] = num_c[k][Q_W] ^ pre_dneg;
			u_c[k]   = NUM_W'({mag_c[k][Q_W-1:0], {FRAC_BITS{1'b0}}}) + NUM_W'(pre_d >> 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p <= 1'b0;
		end else if (en) begin
			v_p <= v_r[ROOT_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_p <= pre_it;
			d_p  <= pre_d;
			for (int k = 0; k < 4; k++) begin
				u_p[k]   <= u_c[k];
				neg_p[k] <= neg_c[k];
			end
		end
	end

	// Restoring division stages: one quotient bit per stage in each of four lanes.
	logic             v_d   [NUM_W];
	item_t            it_d  [NUM_W];
	logic [DIV_W-1:0] d_d   [NUM_W];
	logic             neg_d [NUM_W][4];
	logic [NUM_W-1:0] u_d   [NUM_W][4];
	logic [DIV_W-1:0] rem_d [NUM_W][4];
	logic [NUM_W-1:0] q_d   [NUM_W][4];

	logic [DIV_W-1:0] dv_in  [NUM_W];
	logic [NUM_W-1:0] du_in  [NUM_W][4];
	logic [DIV_W-1:0] dr_in  [NUM_W][4];
	logic [NUM_W-1:0] dq_in  [NUM_W][4];
	logic [DIV_W:0]   dr_cur [NUM_W][4];
	logic [DIV_W-1:0] dr_nx  [NUM_W][4];
	logic [NUM_W-1:0] dq_nx  [NUM_W][4];

	always_comb begin
		for (int j = 0; j < NUM_W; j++) begin
			dv_in[j] = (j == 0) ? d_p : d_d[(j == 0) ? 0 : j - 1];
			for (int k = 0; k < 4; k++) begin
				if (j == 0) begin
					du_in[j][k] = u_p[k];
					dr_in[j][k] = '0;
					dq_in[j][k] = '0;
				end else begin
					du_in[j][k] = u_d[j-1][k];
					dr_in[j][k] = rem_d[j-1][k];
					dq_in[j][k] = q_d[j-1][k];
				end
				dr_cur[j][k] = {dr_in[j][k], du_in[j][k][NUM_W-1]};
				if (dr_cur[j][k] >= {1'b0, dv_in[j]}) begin
					dr_nx[j][k] = DIV_W'(dr_cur[j][k] - {1'b0, dv_in[j]});
					dq_nx[j][k] = {dq_in[j][k][NUM_W-2:0], 1'b1};
				end else begin
					dr_nx[j][k] = DIV_W'(dr_cur[j][k]);
					dq_nx[j][k] = {dq_in[j][k][NUM_W-2:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NUM_W; j++) begin
				v_d[j] <= 1'b0;
			end
		end else if (en) begin
			v_d[0] <= v_p;
			for (int j = 1; j < NUM_W; j++) begin
				v_d[j] <= v_d[j-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_d[0] <= it_p;
			for (int k = 0; k < 4; k++) begin
				neg_d[0][k] <= neg_p[k];
			end
			for (int j = 1; j < NUM_W; j++) begin
				it_d[j] <= it_d[j-1];
				for (int k = 0; k < 4; k++) begin
					neg_d[j][k] <= neg_d[j-1][k];
				end
			end
			for (int j = 0; j < NUM_W; j++) begin
				d_d[j] <= dv_in[j];
				for (int k = 0; k < 4; k++) begin
					u_d[j][k]   <= du_in[j][k] << 1;
					rem_d[j][k] <= dr_nx[j][k];
					q_d[j][k]   <= dq_nx[j][k];
				end
			end
		end
	end

	// Quotient sign and saturation.
	logic  v_q;
	item_t it_q;
	item_t post_it;
	logic  post_hit;
	logic [NUM_W-1:0] qv [4];

	always_comb begin
		post_it  = it_d[NUM_W-1];
		post_hit = 1'b0;
		for (int k = 0; k < 4; k++) begin
			qv[k] = q_d[NUM_W-1][k];
			if (!neg_d[NUM_W-1][k]) begin
				if (qv[k] > QPOS_MAX) begin
					post_it.qd[k] = Q_MAX_V;
					post_hit      = 1'b1;
				end else begin
					post_it.qd[k] = Q_W'(qv[k]);
				end
			end else begin
				if (qv[k] > QNEG_MAX) begin
					post_it.qd[k] = Q_MIN_V;
					post_hit      = 1'b1;
				end else begin
					post_it.qd[k] = Q_W'(-qv[k]);
				end
			end
		end
		if ((post_it.op == OP_DIVIDE) || (post_it.op == OP_NORM) ||
			(post_it.op == OP_INV) || (post_it.op == OP_DIFF)) begin
			post_it.sat = post_hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_d[NUM_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_q <= post_it;
		end
	end

	// Multiplier stage: sixteen component products.
	logic                     v_m;
	item_t                    it_m;
	logic signed [PROD_W-1:0] p_m [4][4];
	q_t                       mx  [4];
	q_t                       my  [4];
	logic signed [PROD_W-1:0] p_c [4][4];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			mx[i] = (it_q.op == OP_DIFF) ? it_q.qd[i] : it_q.a[i];
			my[i] = (it_q.op == OP_SCALE) ? it_q.s : it_q.b[i];
		end
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				p_c[i][j] = mx[i] * my[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m <= 1'b0;
		end else if (en) begin
			v_m <= v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_m <= it_q;
			for (int i = 0; i < 4; i++) begin
				for (int j = 0; j < 4; j++) begin
					p_m[i][j] <= p_c[i][j];
				end
			end
		end
	end

	// Rounding stage: round half up to the fixed-point grid.
	logic                     v_rd;
	item_t                    it_rd;
	logic signed [MR_W-1:0]   mr_rd [4][4];
	logic signed [PROD_W-1:0] rnd_c [4][4];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				rnd_c[i][j] = p_m[i][j] + HALF_P;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_rd <= 1'b0;
		end else if (en) begin
			v_rd <= v_m;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_rd <= it_m;
			for (int i = 0; i < 4; i++) begin
				for (int j = 0; j < 4; j++) begin
					mr_rd[i][j] <= MR_W'(rnd_c[i][j] >>> FRAC_BITS);
				end
			end
		end
	end

	// Summing stage: Hamilton rows, or the diagonal for scaling, and the dot product.
	logic                    v_f;
	item_t                   it_f;
	logic signed [ACC_W-1:0] acc_f [4];
	logic signed [ACC_W-1:0] dot_f;
	logic signed [ACC_W-1:0] me    [4][4];
	logic signed [ACC_W-1:0] acc_c [4];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				me[i][j] = ACC_W'(mr_rd[i][j]);
			end
		end
		if (it_rd.op == OP_SCALE) begin
			for (int i = 0; i < 4; i++) begin
				acc_c[i] = me[i][i];
			end
		end else begin
			acc_c[0] = me[0][0] - me[1][1] - me[2][2] - me[3][3];
			acc_c[1] = me[0][1] + me[1][0] + me[2][3] - me[3][2];
			acc_c[2] = me[0][2] + me[2][0] + me[3][1] - me[1][3];
			acc_c[3] = me[0][3] + me[3][0] + me[1][2] - me[2][1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_f <= 1'b0;
		end else if (en) begin
			v_f <= v_rd;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_f  <= it_rd;
			dot_f <= me[0][0] + me[1][1] + me[2][2] + me[3][3];
			for (int i = 0; i < 4; i++) begin
				acc_f[i] <= acc_c[i];
			end
		end
	end

	// Output stage: select by opcode, saturate, and form the status.
	quat_t   r_nx;
	q_t      dot_nx;
	logic    hit_nx;
	status_t st_nx;
	quat_t   r_q;
	q_t      dot_q;
	status_t st_q;

	always_comb begin
		r_nx   = '0;
		dot_nx = '0;
		hit_nx = it_f.sat;
		unique case (it_f.op)
			OP_MUL, OP_SCALE, OP_DIFF: begin
				for (int k = 0; k < 4; k++) begin
					r_nx[k] = clamp_q(acc_f[k]);
					if (out_of_range(acc_f[k])) begin
						hit_nx = 1'b1;
					end
				end
			end
			OP_DOT: begin
				dot_nx = clamp_q(dot_f);
				if (out_of_range(dot_f)) begin
					hit_nx = 1'b1;
				end
			end
			OP_DIVIDE, OP_NORM, OP_INV: begin
				r_nx = it_f.qd;
			end
			OP_CONJ: begin
				r_nx[0] = it_f.a[0];
				for (int k = 1; k < 4; k++) begin
					if (it_f.a[k] == Q_MIN_V) begin
						r_nx[k] = Q_MAX_V;
						hit_nx  = 1'b1;
					end else begin
						r_nx[k] = -it_f.a[k];
					end
				end
			end
		endcase
		if (it_f.err) begin
			r_nx   = '0;
			dot_nx = '0;
			st_nx  = ST_ZERO;
		end else begin
			st_nx = hit_nx ? ST_SAT : ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
		end else if (en) begin
			ovld_q <= v_f;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_q   <= r_nx;
			dot_q <= dot_nx;
			st_q  <= st_nx;
		end
	end

	assign m_tvalid = ovld_q;
	assign m_tdata  = {dot_q, r_q[3], r_q[2], r_q[1], r_q[0]};
	assign m_tuser  = st_q;

	// Terms for the checks below, kept apart to keep the checks short.
	logic zero_out;
	logic div_zero_p;
	logic rem_ok;

	assign zero_out   = m_tvalid && (m_tuser == ST_ZERO);
	assign div_zero_p = v_p && (it_p.op == OP_DIVIDE) && (it_p.s == '0);
	assign rem_ok     = (d_d[NUM_W-1] == '0) ||
		((rem_d[NUM_W-1][0] < d_d[NUM_W-1]) && (rem_d[NUM_W-1][1] < d_d[NUM_W-1]) &&
		(rem_d[NUM_W-1][2] < d_d[NUM_W-1]) && (rem_d[NUM_W-1][3] < d_d[NUM_W-1]));

	`QAU_ASSERT_NOW(a_zero_status_clears, zero_out, m_tdata == '0, "error result not cleared")
	`QAU_ASSERT_NOW(a_div_zero_flag, div_zero_p, it_p.err, "zero divisor not flagged")
	`QAU_ASSERT_NOW(a_rem_bound, v_d[NUM_W-1], rem_ok, "division remainder not below divisor")
	`QAU_ASSERT_NEXT(a_entry, s_tvalid && s_tready, v_s1, "accepted request did not enter the pipeline")

endmodule

`default_nettype wire
